[src/tjang_pkg.sv]
package tjang_pkg;

  localparam int CoordW      = 16;
  localparam int DiffW       = CoordW + 1;
  localparam int ProdW       = 2 * DiffW;
  localparam int SumW        = ProdW + 1;
  localparam int CordicW     = SumW + 3;
  localparam int ZW          = 26;
  localparam int AngW        = 16;
  localparam int ShiftW      = 5;
  localparam int CordicSteps = 16;
  localparam int TabDepth    = 24;
  localparam int NumCells    = (CordicSteps > TabDepth) ? TabDepth : CordicSteps;

  localparam logic signed [ZW-1:0] ZQuarter = ZW'(4194304);
  localparam logic signed [ZW-1:0] ZRound   = ZW'(128);
  localparam logic signed [ZW-1:0] AngMax   = ZW'(32767);
  localparam logic signed [ZW-1:0] AngMin   = -ZW'(32768);
  localparam logic signed [ZW-1:0] AngPi    = ZW'(32768);

  typedef struct packed {
    logic                      vld;
    logic                      degen;
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [ZW-1:0]      z;
  } stage_t;

  // atan(2^-i) in binary angle units with 8 fraction bits
  function automatic logic signed [ZW-1:0] atan_entry(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:       v = ZW'(2097152);
      1:       v = ZW'(1238021);
      2:       v = ZW'(654136);
      3:       v = ZW'(332050);
      4:       v = ZW'(166669);
      5:       v = ZW'(83416);
      6:       v = ZW'(41718);
      7:       v = ZW'(20860);
      8:       v = ZW'(10430);
      9:       v = ZW'(5215);
      10:      v = ZW'(2608);
      11:      v = ZW'(1304);
      12:      v = ZW'(652);
      13:      v = ZW'(326);
      14:      v = ZW'(163);
      15:      v = ZW'(81);
      16:      v = ZW'(41);
      17:      v = ZW'(20);
      18:      v = ZW'(10);
      19:      v = ZW'(5);
      20:      v = ZW'(3);
      21:      v = ZW'(1);
      22:      v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [ShiftW-1:0] step_shift(input int idx);
    logic [ShiftW-1:0] s;
    s = idx[ShiftW-1:0];
    return s;
  endfunction

endpackage

[src/three_point_joint_angle_core.sv]
// channel | direction | words                                  | handshake
// in      | input     | a_x, a_y, b_x, b_y, c_x, c_y (s16 each)  | in_valid_i / in_ready_o
// out     | output    | signed_angle s16, unsigned_angle u16,  | out_valid_o / out_ready_i
//         |           | degenerate u1                          |
//
// One word per cycle enters while the output is not stalled; a result passes
// through four front stages, one cell per CORDIC step and one output register.
// The depth of the cell row sets the latency.
// Reset clears only the valid bits; the row is empty right after reset.
// Every stage holds its own ready, so a stalled output holds only the stages
// that are full and bubbles further up still close.
module three_point_joint_angle_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [tjang_pkg::CoordW-1:0] a_x_i,
  input  logic signed [tjang_pkg::CoordW-1:0] a_y_i,
  input  logic signed [tjang_pkg::CoordW-1:0] b_x_i,
  input  logic signed [tjang_pkg::CoordW-1:0] b_y_i,
  input  logic signed [tjang_pkg::CoordW-1:0] c_x_i,
  input  logic signed [tjang_pkg::CoordW-1:0] c_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [tjang_pkg::AngW-1:0]   signed_angle_o,
  output logic [tjang_pkg::AngW-1:0]          unsigned_angle_o,
  output logic                                degenerate_o
);

  // stg[k] feeds cell k; load[k] tells the stage ahead of cell k to advance
  tjang_pkg::stage_t stg  [tjang_pkg::NumCells+1];
  logic              load [tjang_pkg::NumCells+1];

  // difference vectors, cross and dot products, quarter-turn pre-rotation
  tjang_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .a_x_i      (a_x_i),
    .a_y_i      (a_y_i),
    .b_x_i      (b_x_i),
    .b_y_i      (b_y_i),
    .c_x_i      (c_x_i),
    .c_y_i      (c_y_i),
    .load_i     (load[0]),
    .stage_o    (stg[0])
  );

  // one CORDIC vectoring step per cell; shift and angle step are fixed per cell
  for (genvar k = 0; k < tjang_pkg::NumCells; k++) begin : g_cell
    tjang_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (tjang_pkg::step_shift(k)),
      .atan_i  (tjang_pkg::atan_entry(k)),
      .stage_i (stg[k]),
      .load_i  (load[k+1]),
      .load_o  (load[k]),
      .stage_o (stg[k+1])
    );
  end

  // round the angle to whole units, clamp, zero it for a degenerate input, and hold the result word
  tjang_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .stage_i          (stg[tjang_pkg::NumCells]),
    .load_o           (load[tjang_pkg::NumCells]),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .signed_angle_o   (signed_angle_o),
    .unsigned_angle_o (unsigned_angle_o),
    .degenerate_o     (degenerate_o)
  );

endmodule

[src/tjang_front.sv]
module tjang_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [tjang_pkg::CoordW-1:0]    a_x_i,
  input  logic signed [tjang_pkg::CoordW-1:0]    a_y_i,
  input  logic signed [tjang_pkg::CoordW-1:0]    b_x_i,
  input  logic signed [tjang_pkg::CoordW-1:0]    b_y_i,
  input  logic signed [tjang_pkg::CoordW-1:0]    c_x_i,
  input  logic signed [tjang_pkg::CoordW-1:0]    c_y_i,
  input  logic                                   load_i,
  output tjang_pkg::stage_t                      stage_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic load1, load2, load3, load4;

  logic signed [tjang_pkg::DiffW-1:0] ux_q, uy_q, vx_q, vy_q;
  logic                               dg1_q, dg2_q, dg3_q;
  logic signed [tjang_pkg::ProdW-1:0] pxx_q, pyy_q, pxy_q, pyx_q;
  logic signed [tjang_pkg::SumW-1:0]  cross_q, dot_q;
  logic signed [tjang_pkg::CordicW-1:0] cross_w, dot_w;
  tjang_pkg::stage_t                  st_d, st_q;

  assign load4      = !v4_q || load_i;
  assign load3      = !v3_q || load4;
  assign load2      = !v2_q || load3;
  assign load1      = !v1_q || load2;
  assign in_ready_o = load1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (load1) v1_q <= in_valid_i;
      if (load2) v2_q <= v1_q;
      if (load3) v3_q <= v2_q;
      if (load4) v4_q <= v3_q;
    end
  end

  assign cross_w = {{(tjang_pkg::CordicW - tjang_pkg::SumW){cross_q[tjang_pkg::SumW-1]}},
                    cross_q};
  assign dot_w   = {{(tjang_pkg::CordicW - tjang_pkg::SumW){dot_q[tjang_pkg::SumW-1]}},
                    dot_q};

  // quarter-turn pre-rotation brings the vector into the right half plane
  always_comb begin
    st_d.vld   = v3_q;
    st_d.degen = dg3_q;
    st_d.x     = dot_w;
    st_d.y     = cross_w;
    st_d.z     = '0;
    if (dot_w < 0) begin
      if (cross_w >= 0) begin
        st_d.x = cross_w;
        st_d.y = -dot_w;
        st_d.z = tjang_pkg::ZQuarter;
      end else begin
        st_d.x = -cross_w;
        st_d.y = dot_w;
        st_d.z = -tjang_pkg::ZQuarter;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load1) begin
      ux_q  <= tjang_pkg::DiffW'(a_x_i) - tjang_pkg::DiffW'(b_x_i);
      uy_q  <= tjang_pkg::DiffW'(a_y_i) - tjang_pkg::DiffW'(b_y_i);
      vx_q  <= tjang_pkg::DiffW'(c_x_i) - tjang_pkg::DiffW'(b_x_i);
      vy_q  <= tjang_pkg::DiffW'(c_y_i) - tjang_pkg::DiffW'(b_y_i);
      dg1_q <= ((a_x_i == b_x_i) && (a_y_i == b_y_i)) ||
               ((c_x_i == b_x_i) && (c_y_i == b_y_i));
    end
    if (load2) begin
      pxx_q <= ux_q * vx_q;
      pyy_q <= uy_q * vy_q;
      pxy_q <= ux_q * vy_q;
      pyx_q <= uy_q * vx_q;
      dg2_q <= dg1_q;
    end
    if (load3) begin
      cross_q <= tjang_pkg::SumW'(pxy_q) - tjang_pkg::SumW'(pyx_q);
      dot_q   <= tjang_pkg::SumW'(pxx_q) + tjang_pkg::SumW'(pyy_q);
      dg3_q   <= dg2_q;
    end
    if (load4) begin
      st_q.vld   <= st_d.vld;
      st_q.degen <= st_d.degen;
      st_q.x     <= st_d.x;
      st_q.y     <= st_d.y;
      st_q.z     <= st_d.z;
    end
  end

  always_comb begin
    stage_o     = st_q;
    stage_o.vld = v4_q;
  end

endmodule

[src/tjang_cell.sv]
module tjang_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [tjang_pkg::ShiftW-1:0]       shift_i,
  input  logic signed [tjang_pkg::ZW-1:0]    atan_i,
  input  tjang_pkg::stage_t                  stage_i,
  input  logic                               load_i,
  output logic                               load_o,
  output tjang_pkg::stage_t                  stage_o
);

  logic                                 vld_q;
  tjang_pkg::stage_t                    st_q;
  logic signed [tjang_pkg::CordicW-1:0] xs, ys;

  assign load_o = !vld_q || load_i;
  assign xs     = stage_i.x >>> shift_i;
  assign ys     = stage_i.y >>> shift_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_o) begin
      vld_q <= stage_i.vld;
    end
  end

  // rotate toward the x axis; a zero y counts as non-negative
  always_ff @(posedge clk_i) begin
    if (load_o) begin
      st_q.vld   <= stage_i.vld;
      st_q.degen <= stage_i.degen;
      if (stage_i.y < 0) begin
        st_q.x <= stage_i.x - ys;
        st_q.y <= stage_i.y + xs;
        st_q.z <= stage_i.z - atan_i;
      end else begin
        st_q.x <= stage_i.x + ys;
        st_q.y <= stage_i.y - xs;
        st_q.z <= stage_i.z + atan_i;
      end
    end
  end

  always_comb begin
    stage_o     = st_q;
    stage_o.vld = vld_q;
  end

endmodule

[src/tjang_back.sv]
module tjang_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tjang_pkg::stage_t                  stage_i,
  output logic                               load_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [tjang_pkg::AngW-1:0]  signed_angle_o,
  output logic [tjang_pkg::AngW-1:0]         unsigned_angle_o,
  output logic                               degenerate_o
);

  logic                              vld_q;
  logic signed [tjang_pkg::ZW-1:0]   r, r_abs, sa, ua;
  logic signed [tjang_pkg::AngW-1:0] sa_q;
  logic [tjang_pkg::AngW-1:0]        ua_q;
  logic                              dg_q;

  assign load_o = !vld_q || out_ready_i;

  always_comb begin
    r     = (stage_i.z + tjang_pkg::ZRound) >>> 8;
    r_abs = (r < 0) ? -r : r;
    sa    = r;
    if (r > tjang_pkg::AngMax) sa = tjang_pkg::AngMax;
    if (r < tjang_pkg::AngMin) sa = tjang_pkg::AngMin;
    ua    = (r_abs > tjang_pkg::AngPi) ? tjang_pkg::AngPi : r_abs;
    if (stage_i.degen) begin
      sa = '0;
      ua = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_o) begin
      vld_q <= stage_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      sa_q <= sa[tjang_pkg::AngW-1:0];
      ua_q <= ua[tjang_pkg::AngW-1:0];
      dg_q <= stage_i.degen;
    end
  end

  assign out_valid_o      = vld_q;
  assign signed_angle_o   = sa_q;
  assign unsigned_angle_o = ua_q;
  assign degenerate_o     = dg_q;

endmodule

[src/tjang_checker.sv]
module tjang_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [tjang_pkg::AngW-1:0]   signed_angle_o,
  input logic [tjang_pkg::AngW-1:0]          unsigned_angle_o,
  input logic                                degenerate_o
);

  logic signed [tjang_pkg::AngW:0] sa_ext;
  logic [tjang_pkg::AngW:0]        sa_abs;
  logic [tjang_pkg::AngW:0]        ua_ext;

  assign sa_ext = {signed_angle_o[tjang_pkg::AngW-1], signed_angle_o};
  assign sa_abs = (sa_ext < 0) ? -sa_ext : sa_ext;
  assign ua_ext = {1'b0, unsigned_angle_o};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(signed_angle_o) &&
      $stable(unsigned_angle_o) && $stable(degenerate_o))
    else $error("result word changed while stalled");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> signed_angle_o == '0 && unsigned_angle_o == '0)
    else $error("degenerate result carries a nonzero angle");

  a_ua_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ua_ext <= 17'd32768)
    else $error("unsigned angle beyond pi");

  a_ua_magnitude: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !degenerate_o |-> (ua_ext == sa_abs) ||
      (signed_angle_o == 16'sd32767 && unsigned_angle_o == 16'd32768))
    else $error("unsigned angle is not the magnitude of the signed angle");

endmodule

bind three_point_joint_angle_core tjang_checker u_tjang_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .signed_angle_o   (signed_angle_o),
  .unsigned_angle_o (unsigned_angle_o),
  .degenerate_o     (degenerate_o)
);
